>>> hw/rtl/lrp_pkg.sv
// Shared types and constants for the longest-prefix route table.
// Used by lrp_front, lrp_queue, lrp_back and longest_prefix_route_table.
// No dependencies.
package lrp_pkg;

  localparam int ADDR_BITS   = 32;
  localparam int PORT_COUNT  = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  localparam logic [2:0] ST_ADDED      = 3'd0;
  localparam logic [2:0] ST_REPLACED   = 3'd1;
  localparam logic [2:0] ST_FORWARDED  = 3'd2;
  localparam logic [2:0] ST_NO_ROUTE   = 3'd3;
  localparam logic [2:0] ST_TTL_EXPIRED = 3'd4;
  localparam logic [2:0] ST_TABLE_FULL = 3'd5;

  typedef struct packed {
    logic        operation;
    logic [31:0] net_prefix;
    logic [5:0]  net_len;
    logic        has_next_hop;
    logic [31:0] gateway_addr;
    logic [3:0]  out_port;
    logic [31:0] dest_addr;
    logic [7:0]  ttl_in;
  } request_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  send_port;
    logic [31:0] hop_addr;
    logic [7:0]  ttl_out;
  } result_t;

  // Classified command as it travels from the front part to the back part
  typedef struct packed {
    logic        is_route;
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        has_gw;
    logic [31:0] gw;
    logic [3:0]  port;
    logic [31:0] dest;
    logic        ttl_ok;
    logic [7:0]  ttl_dec;
  } item_t;

endpackage

>>> hw/rtl/lrp_front.sv
// Front part: accepts commands, saturates the length, reduces the port,
// precomputes the TTL checks and holds one classified command. Uses lrp_pkg.
module lrp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lrp_pkg::request_t request,
  input  logic              q_full,
  output logic              push,
  output lrp_pkg::item_t    item
);

  logic           hold_vld;
  lrp_pkg::item_t item_next;
  logic [8:0]     port_red;

  always_comb begin
    port_red = 9'(request.out_port);
    for (int k = 0; k < 8; k++) begin
      if (port_red >= 9'(lrp_pkg::PORT_COUNT)) begin
        port_red = port_red - 9'(lrp_pkg::PORT_COUNT);
      end
    end
    item_next.is_route = (request.operation == lrp_pkg::OP_ROUTE);
    item_next.prefix   = request.net_prefix;
    item_next.len      = (request.net_len > 6'(lrp_pkg::ADDR_BITS)) ?
                         6'(lrp_pkg::ADDR_BITS) : request.net_len;
    item_next.has_gw   = request.has_next_hop;
    item_next.gw       = request.gateway_addr;
    item_next.port     = port_red[3:0];
    item_next.dest     = request.dest_addr;
    item_next.ttl_ok   = (request.ttl_in > 8'd1);
    item_next.ttl_dec  = request.ttl_in - 8'd1;
  end

  assign push = hold_vld && !q_full;
  assign busy = hold_vld && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (start && !busy) begin
      hold_vld <= 1'b1;
    end else if (push) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item <= item_next;
    end
  end

endmodule

>>> hw/rtl/lrp_queue.sv
// Short command queue between the front and back parts.
// Uses lrp_pkg for the item type and depth.
module lrp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lrp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output lrp_pkg::item_t head
);

  lrp_pkg::item_t              slots [lrp_pkg::QUEUE_DEPTH];
  logic [lrp_pkg::QPW-1:0]     wr_ptr;
  logic [lrp_pkg::QPW-1:0]     rd_ptr;
  logic [lrp_pkg::QCW-1:0]     fill;

  assign full  = (fill == lrp_pkg::QCW'(lrp_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lrp_pkg::QPW'(lrp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + lrp_pkg::QPW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == lrp_pkg::QPW'(lrp_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + lrp_pkg::QPW'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + lrp_pkg::QCW'(1);
        2'b01:   fill <= fill - lrp_pkg::QCW'(1);
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> hw/rtl/lrp_back.sv
// Back part: route table memory and the scan sequencer that serves add and
// route commands one table entry a cycle. Uses lrp_pkg.
module lrp_back #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  lrp_pkg::item_t   q_head,
  output logic             pop,
  output logic             done,
  output lrp_pkg::result_t result
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  typedef struct packed {
    logic [31:0]   prefix;
    logic [5:0]    len;
    logic          has_gw;
    logic [31:0]   gw;
    logic [3:0]    port;
    logic [IW-1:0] rank;
  } entry_t;

  entry_t           mem [TABLE_DEPTH];
  entry_t           rd_q;
  logic [1:0]       state;
  lrp_pkg::item_t   item;
  logic [CW-1:0]    entry_count;
  logic [CW-1:0]    issue_addr;
  logic             rd_vld;
  logic [IW-1:0]    rd_idx;
  logic             age_pass;
  logic             found;
  logic [5:0]       best_len;
  logic [IW-1:0]    best_rank;
  logic [3:0]       best_port;
  logic             best_has_gw;
  logic [31:0]      best_gw;
  logic [IW-1:0]    hit_idx;
  logic [IW-1:0]    hit_rank;

  logic             issue;
  logic             rd_en;
  logic             scan_end;
  logic [31:0]      mask;
  logic             prefix_hit;
  logic             better;
  logic             exact_hit;
  logic             table_full;
  entry_t           new_entry;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  entry_t           wr_data;
  lrp_pkg::result_t res_next;

  always_comb begin
    issue      = (issue_addr < entry_count);
    rd_en      = (state == S_SCAN) && issue;
    scan_end   = (state == S_SCAN) && !issue && !rd_vld;
    pop        = (state == S_IDLE) && !q_empty;
    mask       = ~(32'hFFFF_FFFF >> rd_q.len);
    prefix_hit = (((rd_q.prefix ^ item.dest) & mask) == 32'd0);
    better     = !found || (rd_q.len > best_len) ||
                 ((rd_q.len == best_len) && (rd_q.rank < best_rank));
    exact_hit  = (rd_q.prefix == item.prefix) && (rd_q.len == item.len);
    table_full = (entry_count == CW'(TABLE_DEPTH));

    new_entry.prefix = item.prefix;
    new_entry.len    = item.len;
    new_entry.has_gw = item.has_gw;
    new_entry.gw     = item.gw;
    new_entry.port   = item.port;
    new_entry.rank   = '0;

    wr_en   = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_q;
    if ((state == S_SCAN) && rd_vld && age_pass) begin
      // replaced entry becomes newest; newer ones move down one rank
      if (rd_idx == hit_idx) begin
        wr_en        = 1'b1;
        wr_data      = new_entry;
        wr_data.rank = IW'(entry_count - CW'(1));
      end else if (rd_q.rank > hit_rank) begin
        wr_en        = 1'b1;
        wr_data.rank = rd_q.rank - IW'(1);
      end
    end else if ((state == S_FINISH) && !item.is_route && !found && !table_full) begin
      // valid entries are packed low, so the lowest free slot is the count
      wr_en        = 1'b1;
      wr_addr      = entry_count[IW-1:0];
      wr_data      = new_entry;
      wr_data.rank = entry_count[IW-1:0];
    end

    res_next = '0;
    if (item.is_route) begin
      if (!found) begin
        res_next.status = lrp_pkg::ST_NO_ROUTE;
      end else if (!item.ttl_ok) begin
        res_next.status = lrp_pkg::ST_TTL_EXPIRED;
      end else begin
        res_next.status    = lrp_pkg::ST_FORWARDED;
        res_next.send_port = best_port;
        res_next.hop_addr  = best_has_gw ? best_gw : item.dest;
        res_next.ttl_out   = item.ttl_dec;
      end
    end else if (found) begin
      res_next.status = lrp_pkg::ST_REPLACED;
    end else if (table_full) begin
      res_next.status = lrp_pkg::ST_TABLE_FULL;
    end else begin
      res_next.status = lrp_pkg::ST_ADDED;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[issue_addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      issue_addr  <= '0;
      rd_vld      <= 1'b0;
      age_pass    <= 1'b0;
      found       <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            issue_addr <= '0;
            rd_vld     <= 1'b0;
            age_pass   <= 1'b0;
            found      <= 1'b0;
            state      <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_vld <= issue;
          if (issue) begin
            issue_addr <= issue_addr + CW'(1);
          end
          if (rd_vld && !age_pass) begin
            if (item.is_route ? (prefix_hit && better) : (exact_hit && !found)) begin
              found <= 1'b1;
            end
          end
          if (scan_end) begin
            if (!item.is_route && found && !age_pass) begin
              age_pass   <= 1'b1;
              issue_addr <= '0;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (wr_en) begin
            entry_count <= entry_count + CW'(1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item <= q_head;
    end
    if (rd_en) begin
      rd_idx <= issue_addr[IW-1:0];
    end
    if ((state == S_SCAN) && rd_vld && !age_pass) begin
      if (item.is_route) begin
        if (prefix_hit && better) begin
          best_len    <= rd_q.len;
          best_rank   <= rd_q.rank;
          best_port   <= rd_q.port;
          best_has_gw <= rd_q.has_gw;
          best_gw     <= rd_q.gw;
        end
      end else if (exact_hit && !found) begin
        hit_idx  <= rd_idx;
        hit_rank <= rd_q.rank;
      end
    end
    if (state == S_FINISH) begin
      result <= res_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_packed: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (CW'(wr_addr) <= entry_count))
    else $error("table write leaves a hole above the valid entries");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_fwd_ttl: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == lrp_pkg::ST_FORWARDED)) |-> (result.ttl_out != 8'd0))
    else $error("forwarded with an expired TTL");

  a_age_after_hit: assert property (@(posedge clk) disable iff (rst)
    age_pass |-> (found && !item.is_route))
    else $error("rank update pass without a matching entry");

endmodule

>>> hw/rtl/longest_prefix_route_table.sv
// Top level of the IPv4 longest-prefix route table.
// Depends on lrp_pkg, lrp_front, lrp_queue and lrp_back.
//
//  channel | ports                     | transfer
//  --------+---------------------------+--------------------------------
//  command | start, busy, request      | edge with start high, busy low
//  result  | done, result              | edge ending the cycle done is high
//
// The back part reads the table memory one entry a cycle, for route and add
// commands alike; an add that replaces a route makes a second pass, which
// rewrites the age ranks.
// Reset clears the table at once (entry count to zero); no clearing pass.
// busy rises only while the front holding register and the queue are full;
// results cannot be held off and appear on done for one cycle each.
module longest_prefix_route_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  lrp_pkg::request_t request,
  output logic              done,
  output lrp_pkg::result_t  result
);

  logic           push;
  logic           q_full;
  logic           q_empty;
  logic           pop;
  lrp_pkg::item_t front_item;
  lrp_pkg::item_t q_head;

  lrp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .q_full  (q_full),
    .push    (push),
    .item    (front_item)
  );

  lrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  lrp_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .done    (done),
    .result  (result)
  );

endmodule

>>> test/tb_longest_prefix_route_table.sv
// Self-checking testbench for longest_prefix_route_table: directed and random add and
// route commands, checked against an in-bench copy of the route table.
// Depends on lrp_pkg and the longest_prefix_route_table RTL.
module tb_longest_prefix_route_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 64;
  localparam int RANDOM_ITEMS = 1100;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
  localparam int CYCLE_LIMIT  = 800000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  lrp_pkg::request_t route_req = '0;
  logic              done;
  lrp_pkg::result_t  route_rsp;

  longest_prefix_route_table #(
    .TABLE_DEPTH(DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(route_req),
    .done   (done),
    .result (route_rsp)
  );

  // Shadow route table
  logic        tbl_valid  [DEPTH] = '{default: 1'b0};
  logic [31:0] tbl_prefix [DEPTH];
  int          tbl_len    [DEPTH] = '{default: 0};
  logic        tbl_has_gw [DEPTH];
  logic [31:0] tbl_gw     [DEPTH];
  logic [3:0]  tbl_port   [DEPTH];
  int          tbl_rank   [DEPTH] = '{default: 0};
  int          tbl_count = 0;

  lrp_pkg::request_t pending_cmds[$];
  lrp_pkg::result_t  expected_results[$];
  int                accepted_cmds = 0;
  int                total_cmds;
  int                errors = 0;
  int                cycles = 0;

  function automatic void queue_cmd(lrp_pkg::request_t rq);
    pending_cmds.insert(pending_cmds.size(), rq);
  endfunction

  function automatic logic [31:0] prefix_mask(int len);
    if (len <= 0) return 32'h0;
    if (len >= 32) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF << (32 - len);
  endfunction

  // Apply one command to the shadow table and return the answer it must produce
  function automatic lrp_pkg::result_t table_apply(lrp_pkg::request_t rq);
    lrp_pkg::result_t res;
    int      slot;
    int      best;
    int      len;
    int      old_rank;
    res = '0;
    if (rq.operation == lrp_pkg::OP_ADD) begin
      len = (rq.net_len > 32) ? 32 : int'(rq.net_len);
      slot = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot < 0 && tbl_valid[i] && tbl_prefix[i] == rq.net_prefix && tbl_len[i] == len)
          slot = i;
      end
      if (slot >= 0) begin
        // replaced route becomes newest, newer ones close the gap
        old_rank = tbl_rank[slot];
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_valid[i] && tbl_rank[i] > old_rank) tbl_rank[i]--;
        end
        tbl_rank[slot] = tbl_count - 1;
        res.status = lrp_pkg::ST_REPLACED;
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot < 0 && !tbl_valid[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = lrp_pkg::ST_TABLE_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_rank[slot] = tbl_count;
          tbl_count++;
          res.status = lrp_pkg::ST_ADDED;
        end
      end
      if (slot >= 0) begin
        tbl_prefix[slot] = rq.net_prefix;
        tbl_len[slot]    = len;
        tbl_has_gw[slot] = rq.has_next_hop;
        tbl_gw[slot]     = rq.gateway_addr;
        tbl_port[slot]   = rq.out_port;
      end
    end else begin
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i] && ((tbl_prefix[i] ^ rq.dest_addr) & prefix_mask(tbl_len[i])) == 0 &&
            (best < 0 || tbl_len[i] > tbl_len[best] ||
             (tbl_len[i] == tbl_len[best] && tbl_rank[i] < tbl_rank[best])))
          best = i;
      end
      if (best < 0) begin
        res.status = lrp_pkg::ST_NO_ROUTE;
      end else if (rq.ttl_in <= 8'd1) begin
        res.status = lrp_pkg::ST_TTL_EXPIRED;
      end else begin
        res.status    = lrp_pkg::ST_FORWARDED;
        res.send_port = tbl_port[best];
        res.hop_addr  = tbl_has_gw[best] ? tbl_gw[best] : rq.dest_addr;
        res.ttl_out   = rq.ttl_in - 8'd1;
      end
    end
    return res;
  endfunction

  // Unused fields of each command carry random values
  function automatic lrp_pkg::request_t make_add(logic [31:0] prefix, logic [5:0] len,
                                                 logic gw_flag, logic [31:0] gw,
                                                 logic [3:0] port);
    lrp_pkg::request_t rq;
    rq.operation    = lrp_pkg::OP_ADD;
    rq.net_prefix   = prefix;
    rq.net_len      = len;
    rq.has_next_hop = gw_flag;
    rq.gateway_addr = gw;
    rq.out_port     = port;
    rq.dest_addr    = $urandom;
    rq.ttl_in       = 8'($urandom);
    return rq;
  endfunction

  function automatic lrp_pkg::request_t make_route(logic [31:0] dest, logic [7:0] ttl);
    lrp_pkg::request_t rq;
    rq.operation    = lrp_pkg::OP_ROUTE;
    rq.net_prefix   = $urandom;
    rq.net_len      = 6'($urandom);
    rq.has_next_hop = 1'($urandom);
    rq.gateway_addr = $urandom;
    rq.out_port     = 4'($urandom);
    rq.dest_addr    = dest;
    rq.ttl_in       = ttl;
    return rq;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Command driver
  always @(posedge clk) begin
    int idle_pct;
    if (rst) begin
      start     <= 1'b0;
      route_req <= '0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_results.insert(expected_results.size(), table_apply(route_req));
        void'(pending_cmds.pop_front());
        accepted_cmds <= accepted_cmds + 1;
      end
      if (accepted_cmds < total_cmds / 3) idle_pct = 8;
      else if (accepted_cmds < 2 * total_cmds / 3) idle_pct = 52;
      else idle_pct = 0;
      if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start     <= 1'b1;
        route_req <= pending_cmds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    lrp_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: status %0d port %0d hop %h ttl %0d", $realtime,
                 route_rsp.status, route_rsp.send_port, route_rsp.hop_addr, route_rsp.ttl_out);
        errors <= errors + 1;
      end else begin
        want = expected_results.pop_front();
        if (route_rsp.status !== want.status || route_rsp.send_port !== want.send_port ||
            route_rsp.hop_addr !== want.hop_addr || route_rsp.ttl_out !== want.ttl_out) begin
          $display("%0t mismatch: expected status %0d port %0d hop %h ttl %0d,", $realtime,
                   want.status, want.send_port, want.hop_addr, want.ttl_out,
                   " got status %0d port %0d hop %h ttl %0d", route_rsp.status,
                   route_rsp.send_port, route_rsp.hop_addr, route_rsp.ttl_out);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    logic [31:0] pool_prefix[$];
    logic [5:0]  pool_len[$];
    logic [31:0] base;
    logic [31:0] dest;
    logic [5:0]  len;
    logic [7:0]  ttl;
    int          pick;
    int          keep;
    int          r;

    // Empty table: no route, whatever the TTL
    queue_cmd(make_route(32'h0000_0000, 8'hFF));
    queue_cmd(make_route(32'hFFFF_FFFF, 8'h00));
    // Default route matches everything; direct route TTL is checked too
    queue_cmd(make_add(32'h0000_0000, 6'd0, 1'b0, 32'hFFFF_FFFF, 4'hF));
    queue_cmd(make_route(32'hFFFF_FFFF, 8'hFF));
    queue_cmd(make_route(32'h1234_5678, 8'h01));
    queue_cmd(make_route(32'h1234_5678, 8'h00));
    queue_cmd(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'hFFFF_FFFF, 4'h3));
    queue_cmd(make_add(32'h0A01_0000, 6'd16, 1'b1, 32'h0A00_0001, 4'h0));
    queue_cmd(make_route(32'h0A01_0203, 8'h02));
    queue_cmd(make_route(32'h0A02_0000, 8'h40));
    // Oversized length saturates, so the /32 add replaces it
    queue_cmd(make_add(32'hFFFF_FFFF, 6'd63, 1'b1, 32'h0000_0000, 4'h7));
    queue_cmd(make_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h5555_AAAA, 4'h8));
    queue_cmd(make_route(32'hFFFF_FFFF, 8'h80));
    // Equal-length tie: oldest wins until the older one is replaced
    queue_cmd(make_add(32'h0A00_0005, 6'd8, 1'b1, 32'hAAAA_5555, 4'h9));
    queue_cmd(make_route(32'h0A09_0909, 8'hFF));
    queue_cmd(make_add(32'h0A00_0000, 6'd8, 1'b0, 32'h0000_0000, 4'hC));
    queue_cmd(make_route(32'h0A09_0909, 8'hFF));
    queue_cmd(make_add(32'h8000_0000, 6'd1, 1'b0, 32'h1357_9BDF, 4'hF));
    queue_cmd(make_route(32'h8000_0001, 8'hFF));
    queue_cmd(make_route(32'h7FFF_FFFF, 8'h02));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 14) begin
        if (pool_prefix.size() > 0 && $urandom_range(0, 2) == 0) begin
          // same prefix and length again: a replace when that route was stored
          pick = $urandom_range(0, pool_prefix.size() - 1);
          queue_cmd(make_add(pool_prefix[pick], pool_len[pick], 1'($urandom),
                             $urandom, 4'($urandom)));
        end else begin
          case ($urandom_range(0, 9))
            0: len = 6'($urandom_range(33, 63));
            1: len = 6'd0;
            default: len = 6'($urandom_range(1, 32));
          endcase
          base = $urandom;
          if (pool_prefix.size() > 0 && $urandom_range(0, 1) == 1) begin
            // nest under an existing prefix
            pick = $urandom_range(0, pool_prefix.size() - 1);
            keep = $urandom_range(0, 32);
            base = (pool_prefix[pick] & prefix_mask(keep)) | (base & ~prefix_mask(keep));
          end
          pool_prefix.insert(pool_prefix.size(), base);
          pool_len.insert(pool_len.size(), len);
          queue_cmd(make_add(base, len, 1'($urandom), $urandom, 4'($urandom)));
        end
      end else begin
        dest = $urandom;
        if (r < 97 && pool_prefix.size() > 0) begin
          pick = $urandom_range(0, pool_prefix.size() - 1);
          keep = $urandom_range(0, 32);
          dest = (pool_prefix[pick] & prefix_mask(keep)) | (dest & ~prefix_mask(keep));
        end
        ttl = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom);
        queue_cmd(make_route(dest, ttl));
      end
    end
    total_cmds = pending_cmds.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() > 0 || expected_results.size() > 0) @(posedge clk);
    // hold a little longer to catch stray results
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/lrp_pkg.sv
hw/rtl/lrp_front.sv
hw/rtl/lrp_queue.sv
hw/rtl/lrp_back.sv
hw/rtl/longest_prefix_route_table.sv
test/tb_longest_prefix_route_table.sv
